// File: design/mrp_pkg.sv
// ----------------------------------------------------------------------------
// mrp_pkg
// Types and constants shared by the rectangle packer modules.
// ----------------------------------------------------------------------------
`default_nettype none
package mrp_pkg;
   localparam int DIM_W = 13;
   localparam int SUM_W = 14;
   localparam logic [DIM_W-1:0] SHEET_MAX = 13'd4096;
   localparam logic [DIM_W-1:0] SHEET_RESET = 13'd1024;

   typedef struct packed {
      logic [DIM_W-1:0] x;
      logic [DIM_W-1:0] y;
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
   } rect_type;

   typedef struct packed {
      logic [DIM_W-1:0] s1;
      logic [DIM_W-1:0] s2;
      logic             rot;
      logic             fit;
   } score_type;

   // Fit of a (pw x ph) piece into free rect r; short and long leftovers.
   function automatic score_type fit_score(rect_type r, logic [DIM_W-1:0] pw,
                                           logic [DIM_W-1:0] ph, logic rot);
      score_type s;
      logic [DIM_W-1:0] a;
      logic [DIM_W-1:0] b;
      a = r.w - pw;
      b = r.h - ph;
      s.fit = (r.w >= pw) && (r.h >= ph);
      s.s1 = (a < b) ? a : b;
      s.s2 = (a < b) ? b : a;
      s.rot = rot;
      return s;
   endfunction

   function automatic logic score_better(score_type n, score_type o);
      return n.fit && (!o.fit || n.s1 < o.s1 || (n.s1 == o.s1 && n.s2 < o.s2));
   endfunction

   function automatic logic rect_in(rect_type a, rect_type b);
      return a.x >= b.x && a.y >= b.y &&
             ({1'b0, a.x} + {1'b0, a.w}) <= ({1'b0, b.x} + {1'b0, b.w}) &&
             ({1'b0, a.y} + {1'b0, a.h}) <= ({1'b0, b.y} + {1'b0, b.h});
   endfunction
endpackage
`default_nettype wire

// File: design/maxrects_sprite_packer_core.sv
// ----------------------------------------------------------------------------
// maxrects_sprite_packer_core
// MaxRects best-short-side-fit packer with rotation, memory based.
// ----------------------------------------------------------------------------
// Usage: sizes arrive on req_ (valid/ready); each transfer stores one size
// in the item memory, so loading takes one size per cycle while req_ready
// is high. A transfer with req_last_item set starts packing: req_ready drops
// until the batch's last result is taken. Packing works on the free-rectangle
// memory (one read port, one write port, registered read, 2*MAX_FREE deep
// since removed entries hold their slot until compaction): a search round
// over every unplaced item and free entry in both orientations, a split
// pass that kills each overlapped entry and pushes its pieces, a prune pass
// that compares pairs of entries, and a compaction of live entries.
// Each placement yields one rsp_ transfer; a no-fit result follows if items
// remain. Results sit in an output register; while rsp_ready is low the
// sequencer waits there. Reset clears control state, the item count and
// done bits; the memories are not cleared. The user must write the sheet
// size on csr_ only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none
module maxrects_sprite_packer_core #(
   parameter int MAX_ITEMS = 32,
   parameter int MAX_FREE  = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [12:0] req_item_width,
   input  wire logic [12:0] req_item_height,
   input  wire logic        req_last_item,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [4:0]       rsp_item_index,
   output logic [11:0]      rsp_pos_x,
   output logic [11:0]      rsp_pos_y,
   output logic             rsp_turned,
   output logic             rsp_placed,
   output logic             rsp_table_overflow,
   output logic             rsp_last_result,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   localparam int FREE_DEPTH = 2 * MAX_FREE;
   localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int FW = $clog2(FREE_DEPTH);
   localparam int NW = $clog2(FREE_DEPTH + 1);
   localparam logic [CW-1:0] ITEM_CAP = CW'(MAX_ITEMS);
   localparam logic [NW-1:0] FREE_CAP = NW'(MAX_FREE);

   localparam logic [3:0] ST_LOAD  = 4'd0;
   localparam logic [3:0] ST_SRCH  = 4'd1;
   localparam logic [3:0] ST_SRCHW = 4'd2;
   localparam logic [3:0] ST_DEC   = 4'd3;
   localparam logic [3:0] ST_SPLR  = 4'd4;
   localparam logic [3:0] ST_SPLW  = 4'd5;
   localparam logic [3:0] ST_PRI   = 4'd6;
   localparam logic [3:0] ST_PRJ   = 4'd7;
   localparam logic [3:0] ST_PRC   = 4'd8;
   localparam logic [3:0] ST_CMPR  = 4'd9;
   localparam logic [3:0] ST_CMPW  = 4'd10;
   localparam logic [3:0] ST_OUT   = 4'd11;
   localparam logic [3:0] ST_SPLP  = 4'd12;
   localparam logic [3:0] ST_PRA   = 4'd13;

   logic [12:0] sheet_w, sheet_h;
   mrp_csr u_csr (
      .clock(clock), .reset(reset), .psel(csr_psel), .penable(csr_penable),
      .pwrite(csr_pwrite), .paddr(csr_paddr), .pwdata(csr_pwdata),
      .prdata(csr_prdata), .sheet_w(sheet_w), .sheet_h(sheet_h)
   );
   assign csr_pready = 1'b1;

   // Item memory
   logic [25:0] item_mem [MAX_ITEMS];
   logic [25:0] item_rd_ff;
   logic [IW-1:0] item_ra;
   logic [MAX_ITEMS-1:0] done_ff;
   logic [CW-1:0] count_ff;

   // Free memory with a valid ("alive") bit kept in the entry
   logic [52:0] free_mem [FREE_DEPTH];
   logic [52:0] free_rd_ff;
   logic [FW-1:0] free_ra;
   logic free_we;
   logic [FW-1:0] free_wa;
   logic [52:0] free_wd;
   logic [NW-1:0] fcnt_ff;   // entries in use, dead ones included
   logic [NW-1:0] live_ff;   // live entries during the split pass
   logic ovf_ff;

   logic [3:0] st_ff;
   logic [CW-1:0] k_ff;
   logic [NW-1:0] i_ff, j_ff, n_ff;
   logic o_ff;
   mrp_pkg::score_type best_ff, ib_ff;
   mrp_pkg::rect_type ispot_ff, bspot_ff, a_ff;
   logic bany_ff, bturn_ff, iany_ff;
   logic [IW-1:0] bidx_ff;
   logic [CW-1:0] placed_ff;
   logic [2:0] piece_ff;
   mrp_pkg::rect_type f_ff;

   logic rv_ff;
   logic [4:0] ridx_ff;
   logic [11:0] rx_ff, ry_ff;
   logic rturn_ff, rplaced_ff, rovf_ff, rlast_ff;

   mrp_pkg::rect_type fr;
   assign fr = free_rd_ff[51:0];

   always_ff @(posedge clock) begin
      item_rd_ff <= item_mem[item_ra];
      free_rd_ff <= free_mem[free_ra];
      if (req_valid && req_ready && count_ff < ITEM_CAP)
         item_mem[count_ff[IW-1:0]] <= {req_item_width, req_item_height};
      if (free_we) free_mem[free_wa] <= free_wd;
   end

   assign req_ready = (st_ff == ST_LOAD);

   // Split piece under consideration (piece_ff selects one of four)
   mrp_pkg::rect_type pc;
   logic pc_ok;
   logic [13:0] fr_r, fr_b, ur, ub;
   always_comb begin
      fr_r = {1'b0, f_ff.x} + {1'b0, f_ff.w};
      fr_b = {1'b0, f_ff.y} + {1'b0, f_ff.h};
      ur = {1'b0, bspot_ff.x} + {1'b0, bspot_ff.w};
      ub = {1'b0, bspot_ff.y} + {1'b0, bspot_ff.h};
      pc = f_ff;
      pc_ok = 1'b0;
      case (piece_ff)
         3'd0: begin
            pc_ok = bspot_ff.y > f_ff.y;
            pc.h = bspot_ff.y - f_ff.y;
         end
         3'd1: begin
            pc_ok = ub < fr_b;
            pc.y = ub[12:0];
            pc.h = 13'(fr_b - ub);
         end
         3'd2: begin
            pc_ok = bspot_ff.x > f_ff.x;
            pc.w = bspot_ff.x - f_ff.x;
         end
         3'd3: begin
            pc_ok = ur < fr_r;
            pc.x = ur[12:0];
            pc.w = 13'(fr_r - ur);
         end
         default: pc_ok = 1'b0;
      endcase
   end

   logic pc_push;
   assign pc_push = pc_ok && live_ff < FREE_CAP;

   mrp_pkg::score_type sc;
   logic [12:0] iw, ih;
   assign iw = o_ff ? item_rd_ff[12:0] : item_rd_ff[25:13];
   assign ih = o_ff ? item_rd_ff[25:13] : item_rd_ff[12:0];
   assign sc = mrp_pkg::fit_score(fr, iw, ih, o_ff);

   // Overlap of the placed spot with the entry just read
   logic [13:0] rd_r, rd_b;
   logic overlap;
   assign rd_r = {1'b0, fr.x} + {1'b0, fr.w};
   assign rd_b = {1'b0, fr.y} + {1'b0, fr.h};
   assign overlap = !({1'b0, bspot_ff.x} >= rd_r || ur <= {1'b0, fr.x} ||
                      {1'b0, bspot_ff.y} >= rd_b || ub <= {1'b0, fr.y});

   logic pr_kill_i, pr_kill_j;
   assign pr_kill_i = free_rd_ff[52] && mrp_pkg::rect_in(a_ff, fr);
   assign pr_kill_j = free_rd_ff[52] && !pr_kill_i && mrp_pkg::rect_in(fr, a_ff);

   always_comb begin
      item_ra = k_ff[IW-1:0];
      free_ra = i_ff[FW-1:0];
      free_we = 1'b0;
      free_wa = i_ff[FW-1:0];
      free_wd = {1'b0, fr};
      case (st_ff)
         ST_PRJ: free_ra = j_ff[FW-1:0];
         ST_PRC: begin
            free_ra = j_ff[FW-1:0];
            free_we = pr_kill_i || pr_kill_j;
            free_wa = pr_kill_i ? i_ff[FW-1:0] : j_ff[FW-1:0];
            free_wd = pr_kill_i ? {1'b0, a_ff} : {1'b0, fr};
         end
         ST_SPLP: begin
            free_we = pc_push;
            free_wa = fcnt_ff[FW-1:0];
            free_wd = {1'b1, pc};
         end
         ST_LOAD: begin
            free_we = req_valid && req_last_item;
            free_wa = '0;
            free_wd = {1'b1, 13'd0, 13'd0, sheet_w, sheet_h};
         end
         ST_SPLW: begin
            free_we = free_rd_ff[52] && overlap;
            free_wa = i_ff[FW-1:0];
            free_wd = {1'b0, fr};
         end
         ST_CMPW: begin
            free_we = free_rd_ff[52];
            free_wa = n_ff[FW-1:0];
            free_wd = free_rd_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_LOAD;
         count_ff <= '0;
         done_ff <= '0;
         rv_ff <= 1'b0;
         fcnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         if (rv_ff && rsp_ready) rv_ff <= 1'b0;
         case (st_ff)
            ST_LOAD: if (req_valid) begin
               if (count_ff < ITEM_CAP) count_ff <= count_ff + 1'b1;
               if (req_last_item) begin
                  fcnt_ff <= NW'(1);
                  ovf_ff <= 1'b0;
                  placed_ff <= '0;
                  st_ff <= ST_DEC;
                  k_ff <= '0; i_ff <= '0; o_ff <= 1'b0;
                  bany_ff <= 1'b0; iany_ff <= 1'b0;
                  best_ff <= '0; ib_ff <= '0;
               end
            end
            // Issue a read of free entry i for item k.
            ST_DEC: begin
               if (k_ff >= count_ff) begin
                  if (bany_ff) begin
                     f_ff <= '0;
                     i_ff <= '0;
                     n_ff <= fcnt_ff;
                     live_ff <= fcnt_ff;
                     st_ff <= ST_SPLR;
                  end else begin
                     rv_ff <= placed_ff < count_ff;
                     ridx_ff <= '0; rx_ff <= '0; ry_ff <= '0;
                     rturn_ff <= 1'b0; rplaced_ff <= 1'b0;
                     rovf_ff <= ovf_ff; rlast_ff <= 1'b1;
                     count_ff <= '0; done_ff <= '0;
                     st_ff <= (placed_ff < count_ff) ? ST_OUT : ST_LOAD;
                  end
               end else if (done_ff[k_ff[IW-1:0]] || i_ff >= fcnt_ff) begin
                  if (iany_ff && !done_ff[k_ff[IW-1:0]] &&
                      mrp_pkg::score_better(ib_ff, best_ff)) begin
                     best_ff <= ib_ff; bspot_ff <= ispot_ff;
                     bidx_ff <= k_ff[IW-1:0]; bturn_ff <= ib_ff.rot;
                     bany_ff <= 1'b1;
                  end
                  k_ff <= k_ff + 1'b1; i_ff <= '0; o_ff <= 1'b0;
                  iany_ff <= 1'b0; ib_ff <= '0;
               end else st_ff <= ST_SRCH;
            end
            ST_SRCH: st_ff <= ST_SRCHW;
            ST_SRCHW: begin
               if (free_rd_ff[52] && mrp_pkg::score_better(sc, ib_ff)) begin
                  ib_ff <= sc; iany_ff <= 1'b1;
                  ispot_ff <= '{x: fr.x, y: fr.y, w: iw, h: ih};
               end
               if (o_ff) begin
                  o_ff <= 1'b0; i_ff <= i_ff + 1'b1; st_ff <= ST_DEC;
               end else begin
                  o_ff <= 1'b1; st_ff <= ST_SRCHW;
               end
            end
            // Split: read entry i of the first n, push pieces, kill entry.
            ST_SPLR: begin
               if (i_ff >= n_ff) begin
                  i_ff <= '0;
                  st_ff <= ST_PRI;
               end else st_ff <= ST_SPLW;
            end
            ST_SPLW: begin
               f_ff <= fr;
               if (free_rd_ff[52] && overlap) begin
                  piece_ff <= 3'd0;
                  st_ff <= ST_SPLP;
               end else begin
                  i_ff <= i_ff + 1'b1;
                  st_ff <= ST_SPLR;
               end
            end
            ST_SPLP: begin
               if (pc_push) fcnt_ff <= fcnt_ff + 1'b1;
               else if (pc_ok) ovf_ff <= 1'b1;
               if (piece_ff == 3'd3) begin
                  live_ff <= pc_push ? live_ff : live_ff - 1'b1;
                  i_ff <= i_ff + 1'b1; st_ff <= ST_SPLR;
               end else begin
                  if (pc_push) live_ff <= live_ff + 1'b1;
                  piece_ff <= piece_ff + 1'b1;
               end
            end
            // Prune: entry i against each later j.
            ST_PRI: begin
               if (i_ff >= fcnt_ff) begin
                  i_ff <= '0; n_ff <= '0; st_ff <= ST_CMPR;
               end else begin
                  j_ff <= i_ff + 1'b1; st_ff <= ST_PRA;
               end
            end
            ST_PRA: begin
               a_ff <= fr;
               if (!free_rd_ff[52]) begin
                  i_ff <= i_ff + 1'b1; st_ff <= ST_PRI;
               end else st_ff <= ST_PRJ;
            end
            ST_PRJ: begin
               if (j_ff >= fcnt_ff) begin
                  i_ff <= i_ff + 1'b1; st_ff <= ST_PRI;
               end else st_ff <= ST_PRC;
            end
            ST_PRC: begin
               // free_rd_ff holds entry j; a_ff holds entry i.
               if (pr_kill_i) begin
                  i_ff <= i_ff + 1'b1; st_ff <= ST_PRI;
               end else begin
                  j_ff <= j_ff + 1'b1; st_ff <= ST_PRJ;
               end
            end
            // Compact live entries to the front, then report.
            ST_CMPR: begin
               if (i_ff >= fcnt_ff) begin
                  fcnt_ff <= n_ff;
                  placed_ff <= placed_ff + 1'b1;
                  rv_ff <= 1'b1;
                  ridx_ff <= 5'(bidx_ff);
                  rx_ff <= bspot_ff.x[11:0]; ry_ff <= bspot_ff.y[11:0];
                  rturn_ff <= bturn_ff; rplaced_ff <= 1'b1; rovf_ff <= ovf_ff;
                  rlast_ff <= (placed_ff + 1'b1) == count_ff;
                  if ((placed_ff + 1'b1) == count_ff) begin
                     count_ff <= '0; done_ff <= '0;
                  end else done_ff[bidx_ff] <= 1'b1;
                  st_ff <= ST_OUT;
               end else st_ff <= ST_CMPW;
            end
            ST_CMPW: begin
               if (free_rd_ff[52]) n_ff <= n_ff + 1'b1;
               i_ff <= i_ff + 1'b1;
               st_ff <= ST_CMPR;
            end
            ST_OUT: if (rsp_ready) begin
               if (rlast_ff) st_ff <= ST_LOAD;
               else begin
                  st_ff <= ST_DEC;
                  k_ff <= '0; i_ff <= '0; o_ff <= 1'b0;
                  bany_ff <= 1'b0; iany_ff <= 1'b0;
                  best_ff <= '0; ib_ff <= '0;
               end
            end
            default: st_ff <= ST_LOAD;
         endcase
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_item_index = ridx_ff;
   assign rsp_pos_x = rx_ff;
   assign rsp_pos_y = ry_ff;
   assign rsp_turned = rturn_ff;
   assign rsp_placed = rplaced_ff;
   assign rsp_table_overflow = rovf_ff;
   assign rsp_last_result = rlast_ff;
endmodule
`default_nettype wire

// File: design/mrp_csr.sv
// ----------------------------------------------------------------------------
// mrp_csr
// APB register file holding the sheet size, saturated to the sheet limit.
// ----------------------------------------------------------------------------
`default_nettype none
module mrp_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic [12:0]      sheet_w,
   output logic [12:0]      sheet_h
);
   localparam logic [2:0] ADDR_W = 3'd0;
   localparam logic [2:0] ADDR_H = 3'd4;
   logic [12:0] w_ff, h_ff, val;
   assign val = (pwdata[12:0] > mrp_pkg::SHEET_MAX) ? mrp_pkg::SHEET_MAX : pwdata[12:0];
   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= mrp_pkg::SHEET_RESET;
         h_ff <= mrp_pkg::SHEET_RESET;
      end else if (psel && penable && pwrite) begin
         if (paddr == ADDR_W) w_ff <= val;
         if (paddr == ADDR_H) h_ff <= val;
      end
   end
   always_comb begin
      case (paddr)
         ADDR_W:  prdata = {19'd0, w_ff};
         ADDR_H:  prdata = {19'd0, h_ff};
         default: prdata = 32'd0;
      endcase
   end
   assign sheet_w = w_ff;
   assign sheet_h = h_ff;
endmodule
`default_nettype wire

// File: design/mrp_checker.sv
// ----------------------------------------------------------------------------
// mrp_checker
// Port-level checks for the packer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module mrp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_placed,
   input wire logic       rsp_last_result,
   input wire logic [4:0] rsp_item_index
);
   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input taken while result pending");
   a_nofit_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_placed |-> rsp_last_result) else $error("no-fit not last");
   a_nofit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_placed |-> rsp_item_index == 5'd0) else $error("no-fit index");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item_index))
      else $error("result dropped");
endmodule

bind maxrects_sprite_packer_core mrp_checker u_mrp_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_placed(rsp_placed),
   .rsp_last_result(rsp_last_result), .rsp_item_index(rsp_item_index)
);
`default_nettype wire

// File: verif/maxrects_sprite_packer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maxrects_sprite_packer_checker
// Watches the size, placement and register ports of the rectangle packer,
// keeps its own MaxRects best-short-side-fit packer with rotation and
// compares every placement transfer, field by field, in order.
// ----------------------------------------------------------------------------
module maxrects_sprite_packer_checker #(
   parameter int ITEM_SLOTS = 32,
   parameter int FREE_SLOTS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [12:0] req_item_width,
   input  wire logic [12:0] req_item_height,
   input  wire logic        req_last_item,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [4:0]  rsp_item_index,
   input  wire logic [11:0] rsp_pos_x,
   input  wire logic [11:0] rsp_pos_y,
   input  wire logic        rsp_turned,
   input  wire logic        rsp_placed,
   input  wire logic        rsp_table_overflow,
   input  wire logic        rsp_last_result,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,
   output int               fail_count,
   output int               pending,
   output int               result_count
);
   localparam logic [2:0] ADDR_SHEET_W = 3'd0;
   localparam logic [2:0] ADDR_SHEET_H = 3'd4;

   typedef struct {
      bit [4:0]  idx;
      bit [11:0] x;
      bit [11:0] y;
      bit        turned;
      bit        placed;
      bit        ovf;
      bit        last;
   } placement_type;

   placement_type placement_q[$];

   int unsigned sheet_w = 1024;
   int unsigned sheet_h = 1024;
   int unsigned size_w[ITEM_SLOTS];
   int unsigned size_h[ITEM_SLOTS];
   bit          done[ITEM_SLOTS];
   int          n_items = 0;
   int unsigned fx[FREE_SLOTS];
   int unsigned fy[FREE_SLOTS];
   int unsigned fw[FREE_SLOTS];
   int unsigned fh[FREE_SLOTS];
   int          n_free = 0;
   bit          dropped = 0;

   initial begin
      fail_count = 0;
      result_count = 0;
   end

   assign pending = placement_q.size();

   function automatic void free_add(int unsigned x, int unsigned y, int unsigned w,
                                    int unsigned h);
      if (n_free < FREE_SLOTS) begin
         fx[n_free] = x;
         fy[n_free] = y;
         fw[n_free] = w;
         fh[n_free] = h;
         n_free++;
      end else begin
         dropped = 1;
      end
   endfunction

   function automatic void free_drop(int i);
      for (int k = i; k < n_free - 1; k++) begin
         fx[k] = fx[k+1];
         fy[k] = fy[k+1];
         fw[k] = fw[k+1];
         fh[k] = fh[k+1];
      end
      n_free--;
   endfunction

   function automatic bit carve(int i, int unsigned ux, int unsigned uy, int unsigned uw,
                                int unsigned uh);
      int unsigned x, y, w, h, fr, fb, ur, ub;
      x = fx[i];
      y = fy[i];
      w = fw[i];
      h = fh[i];
      fr = x + w;
      fb = y + h;
      ur = ux + uw;
      ub = uy + uh;
      if (ux >= fr || ur <= x || uy >= fb || ub <= y) return 0;
      if (uy > y) free_add(x, y, w, uy - y);
      if (ub < fb) free_add(x, ub, w, fb - ub);
      if (ux > x) free_add(x, y, ux - x, h);
      if (ur < fr) free_add(ur, y, fr - ur, h);
      return 1;
   endfunction

   function automatic bit held_in(int a, int b);
      return fx[a] >= fx[b] && fy[a] >= fy[b] && fx[a] + fw[a] <= fx[b] + fw[b] &&
             fy[a] + fh[a] <= fy[b] + fh[b];
   endfunction

   function automatic void prune_free();
      int i, j;
      bit gone;
      i = 0;
      while (i < n_free) begin
         j = i + 1;
         gone = 0;
         while (j < n_free) begin
            if (held_in(i, j)) begin
               free_drop(i);
               gone = 1;
               break;
            end
            if (held_in(j, i)) free_drop(j);
            else j++;
         end
         if (!gone) i++;
      end
   endfunction

   function automatic void occupy(int unsigned ux, int unsigned uy, int unsigned uw,
                                  int unsigned uh);
      int n, i;
      n = n_free;
      i = 0;
      while (i < n) begin
         if (carve(i, ux, uy, uw, uh)) begin
            free_drop(i);
            n--;
         end else begin
            i++;
         end
      end
      prune_free();
   endfunction

   function automatic void pack_batch();
      placement_type p;
      int placed_n, best_k;
      bit any, best_rot;
      int unsigned best_s1, best_s2, bx, by, bw, bh;
      int unsigned pw, ph, a, b, s, l;
      n_free = 0;
      dropped = 0;
      placed_n = 0;
      free_add(0, 0, sheet_w, sheet_h);
      forever begin
         any = 0;
         best_k = 0;
         best_rot = 0;
         best_s1 = 0;
         best_s2 = 0;
         for (int k = 0; k < n_items; k++) begin
            if (done[k]) continue;
            // per-item best over free rects, then across items; strict
            // comparisons keep the earliest item, rect and orientation
            for (int i = 0; i < n_free; i++) begin
               for (int o = 0; o < 2; o++) begin
                  pw = o ? size_h[k] : size_w[k];
                  ph = o ? size_w[k] : size_h[k];
                  if (fw[i] >= pw && fh[i] >= ph) begin
                     a = fw[i] - pw;
                     b = fh[i] - ph;
                     s = a < b ? a : b;
                     l = a < b ? b : a;
                     if (!any || s < best_s1 || (s == best_s1 && l < best_s2)) begin
                        any = 1;
                        best_s1 = s;
                        best_s2 = l;
                        best_k = k;
                        best_rot = o != 0;
                        bx = fx[i];
                        by = fy[i];
                        bw = pw;
                        bh = ph;
                     end
                  end
               end
            end
         end
         if (!any) break;
         occupy(bx, by, bw, bh);
         done[best_k] = 1;
         placed_n++;
         p.idx = best_k[4:0];
         p.x = bx[11:0];
         p.y = by[11:0];
         p.turned = best_rot;
         p.placed = 1;
         p.ovf = dropped;
         p.last = placed_n == n_items;
         placement_q.insert(placement_q.size(), p);
      end
      if (placed_n < n_items) begin
         p = '{default: 0};
         p.ovf = dropped;
         p.last = 1;
         placement_q.insert(placement_q.size(), p);
      end
      n_items = 0;
      for (int k = 0; k < ITEM_SLOTS; k++) done[k] = 0;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      placement_type want;
      int unsigned v;
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            v = csr_pwdata & 32'h1FFF;
            if (v > 4096) v = 4096;
            if (csr_paddr == ADDR_SHEET_W) sheet_w = v;
            else if (csr_paddr == ADDR_SHEET_H) sheet_h = v;
         end
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (placement_q.size() == 0) begin
               report_mismatch("outstanding placements", 0, 1);
            end else begin
               want = placement_q.pop_front();
               if (rsp_item_index != want.idx)
                  report_mismatch("item_index", rsp_item_index, want.idx);
               if (rsp_pos_x != want.x) report_mismatch("pos_x", rsp_pos_x, want.x);
               if (rsp_pos_y != want.y) report_mismatch("pos_y", rsp_pos_y, want.y);
               if (rsp_turned != want.turned)
                  report_mismatch("turned", rsp_turned, want.turned);
               if (rsp_placed != want.placed)
                  report_mismatch("placed", rsp_placed, want.placed);
               if (rsp_table_overflow != want.ovf)
                  report_mismatch("table_overflow", rsp_table_overflow, want.ovf);
               if (rsp_last_result != want.last)
                  report_mismatch("last_result", rsp_last_result, want.last);
            end
         end
         if (req_valid && req_ready) begin
            if (n_items < ITEM_SLOTS) begin
               size_w[n_items] = req_item_width;
               size_h[n_items] = req_item_height;
               done[n_items] = 0;
               n_items++;
            end
            if (req_last_item) pack_batch();
         end
      end
   end
endmodule

// File: verif/tb_maxrects_sprite_packer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_maxrects_sprite_packer_core
// Drives batches of rectangle sizes over several sheet sizes, with random
// stalls on both sides, and lets the checker judge the placements.
// ----------------------------------------------------------------------------
module tb_maxrects_sprite_packer_core;
   localparam logic [2:0] ADDR_SHEET_W = 3'd0;
   localparam logic [2:0] ADDR_SHEET_H = 3'd4;
   localparam int STALL_LIMIT = 200000;
   localparam int ITEM_TARGET = 330;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [12:0] req_item_width = 0;
   logic [12:0] req_item_height = 0;
   logic        req_last_item = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [4:0]  rsp_item_index;
   logic [11:0] rsp_pos_x;
   logic [11:0] rsp_pos_y;
   logic        rsp_turned;
   logic        rsp_placed;
   logic        rsp_table_overflow;
   logic        rsp_last_result;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [2:0]  csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count, pending, result_count;
   int items_sent = 0;
   int batches = 0;
   int hold_off = 0;
   bit quiet = 0;
   int unsigned cur_w = 1024;
   int unsigned cur_h = 1024;
   int idle_cycles = 0;

   always #1 clock = ~clock;

   maxrects_sprite_packer_core dut (.*);

   maxrects_sprite_packer_checker checker_i (
      .clock, .reset, .req_valid, .req_ready, .req_item_width, .req_item_height,
      .req_last_item, .rsp_valid, .rsp_ready, .rsp_item_index, .rsp_pos_x, .rsp_pos_y,
      .rsp_turned, .rsp_placed, .rsp_table_overflow, .rsp_last_result, .csr_psel,
      .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .fail_count, .pending, .result_count
   );

   // receiver: random stall bursts, long hold-off on request
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (hold_off > 0) begin
            rsp_ready <= 0;
            hold_off--;
         end else if (quiet) begin
            rsp_ready <= 1;
         end else if (stall > 0) begin
            rsp_ready <= 0;
            stall--;
         end else if ($urandom_range(0, 7) == 0) begin
            rsp_ready <= 0;
            stall = $urandom_range(0, 17);
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_size(int unsigned w, int unsigned h, bit last);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         gap = $urandom_range(1, 18);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_item_width <= w[12:0];
      req_item_height <= h[12:0];
      req_last_item <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (last) batches++;
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   task automatic set_sheet(logic [31:0] w, logic [31:0] h);
      wait_drained();
      csr_write(ADDR_SHEET_W, w);
      csr_write(ADDR_SHEET_H, h);
      cur_w = (w & 32'h1FFF) > 4096 ? 4096 : (w & 32'h1FFF);
      cur_h = (h & 32'h1FFF) > 4096 ? 4096 : (h & 32'h1FFF);
   endtask

   function automatic int unsigned pick_dim(int unsigned side);
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 4096);
         1: case ($urandom_range(0, 3))
               0: return 0;
               1: return 1;
               2: return 4095;
               default: return 4096;
            endcase
         2: return side;
         default: return $urandom_range(1, side / 3 + 1);
      endcase
   endfunction

   task automatic random_batch(int n);
      for (int i = 0; i < n; i++)
         send_size(pick_dim(cur_w), pick_dim(cur_h), i == n - 1);
   endtask

   function automatic int batch_len();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return $urandom_range(7, 20);
      return $urandom_range(1, 6);
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: exact fit, rotation, no fit, zero area, default sheet
      send_size(1024, 1024, 1);
      send_size(1, 1000, 0);
      send_size(1000, 1, 0);
      send_size(4096, 4096, 1);
      send_size(0, 0, 0);
      send_size(0, 1024, 0);
      send_size(1025, 0, 1);
      set_sheet(300, 100);
      send_size(50, 200, 0);
      send_size(100, 300, 0);
      send_size(10, 10, 1);
      set_sheet(32'h1FFF, 0);
      send_size(0, 4096, 0);
      send_size(5, 0, 0);
      send_size(1, 1, 1);
      set_sheet(1, 1);
      send_size(1, 1, 0);
      send_size(1, 1, 1);
      // item table overflow: further sizes ignored, mark still packs
      set_sheet(4096, 4096);
      for (int i = 0; i < 35; i++)
         send_size($urandom_range(1, 900), $urandom_range(1, 900), i == 34);

      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 5))
            0: set_sheet($urandom_range(1, 4096), $urandom_range(1, 4096));
            1: set_sheet($urandom, $urandom);
            2: set_sheet($urandom_range(1, 128), $urandom_range(1, 128));
            default: ;
         endcase
         if (items_sent > ITEM_TARGET - 40) quiet = 1;
         if (!quiet && $urandom_range(0, 14) == 0) begin
            hold_off = 400;
            random_batch(batch_len());
            random_batch(batch_len());
         end else if ($urandom_range(0, 9) == 0) begin
            wait_drained();
            random_batch(batch_len());
         end else begin
            random_batch(batch_len());
         end
      end

      wait_drained();
      repeat (50) @(posedge clock);
      $display("covered %0d sizes in %0d batches, %0d placement transfers checked",
               items_sent, batches, result_count);
      $display("sheets down to empty and up to saturated, stalls on both ports");
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
